### rtl/core/uartdf_pkg.sv
// Shared constants for the UART frame deframer with XOR check.
package uartdf_pkg;

	// Frame buffer depth and its index width
	localparam int unsigned MAX_FRAME = 4096;
	localparam int unsigned IDX_W     = 12;

	// Field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CNT_W   = 17;
	localparam int unsigned HLEN_W  = 16;
	localparam int unsigned FLEN_W  = 17;
	localparam int unsigned OUT_D_W = 40;

	// Configuration register indexes
	localparam logic REG_START_BYTE = 1'b0;
	localparam logic REG_END_BYTE   = 1'b1;

	// Register reset values
	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hA5;
	localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h5A;

endpackage

### rtl/core/uart_frame_deframer_xor_top.sv
// Top level of the UART frame deframer with XOR check.

// Takes one received byte per item and returns exactly one result item per byte.
// It takes one item per cycle while s_tready is high. A byte passes an input register,
// then the result register, with the decode step as combinational logic between those
// two registers. s_tready goes low only when both registers are full and
// m_tready is low. Bytes from the type byte through the body are reported with
// their buffer index. Bytes at an index of MAX_FRAME or more are not stored and are
// counted as overflow. On the trailer byte of a frame that passed the XOR check,
// the block reports frame_done (on m_tlast) with the good flag, the length and
// the overflow flag. A frame that fails the XOR check is dropped without a report.
module uart_frame_deframer_xor_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	// input stream; tdata: rx_byte[7:0]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: store_index[11:0], store_byte[19:12], frame_good[20],
	//        frame_length[37:21], frame_overflow[38], zero[39]
	output logic [39:0] m_tdata,
	// tuser: store_valid[0]
	output logic        m_tuser,
	// tlast: frame_done
	output logic        m_tlast
);

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_TYPE    = 3'd1,
		PH_LEN_HI  = 3'd2,
		PH_LEN_LO  = 3'd3,
		PH_BODY    = 3'd4,
		PH_TRAILER = 3'd5
	} phase_t;

	// configuration registers
	logic [uartdf_pkg::BYTE_W-1:0] start_byte_q;
	logic [uartdf_pkg::BYTE_W-1:0] end_byte_q;

	// frame state
	phase_t                        phase_q;
	logic [uartdf_pkg::CNT_W-1:0]  byte_count_q;
	logic [uartdf_pkg::HLEN_W-1:0] header_length_q;
	logic [uartdf_pkg::BYTE_W-1:0] running_xor_q;
	logic                          overflow_seen_q;

	// input stage
	logic                          valid_s1;
	logic [uartdf_pkg::BYTE_W-1:0] byte_s1;

	// result stage
	logic                          valid_s2;
	logic                          store_valid_s2;
	logic [uartdf_pkg::IDX_W-1:0]  store_index_s2;
	logic [uartdf_pkg::BYTE_W-1:0] store_byte_s2;
	logic                          frame_done_s2;
	logic                          frame_good_s2;
	logic [uartdf_pkg::FLEN_W-1:0] frame_length_s2;
	logic                          frame_overflow_s2;

	// handshake
	logic advance_s2;
	logic take_s1;

	// decode results
	phase_t                        phase_d;
	logic [uartdf_pkg::CNT_W-1:0]  byte_count_d;
	logic [uartdf_pkg::HLEN_W-1:0] header_length_d;
	logic [uartdf_pkg::BYTE_W-1:0] running_xor_d;
	logic                          overflow_seen_d;
	logic                          store_valid_d;
	logic [uartdf_pkg::IDX_W-1:0]  store_index_d;
	logic [uartdf_pkg::BYTE_W-1:0] store_byte_d;
	logic                          frame_done_d;
	logic                          frame_good_d;
	logic [uartdf_pkg::FLEN_W-1:0] frame_length_d;
	logic                          frame_overflow_d;
	logic [uartdf_pkg::CNT_W-1:0]  count_inc;
	logic                          in_buffer;
	logic [uartdf_pkg::CNT_W:0]    body_end;

	// Advance the result stage when the input stage holds a byte and the result stage is empty or being drained
	assign advance_s2 = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready   = !valid_s1 || advance_s2;
	assign take_s1    = s_tvalid && s_tready;

	// Buffer position bookkeeping for a stored byte
	assign count_inc = byte_count_q + uartdf_pkg::CNT_W'(1);
	assign in_buffer = byte_count_q < uartdf_pkg::CNT_W'(uartdf_pkg::MAX_FRAME);
	assign body_end  = {{(uartdf_pkg::CNT_W-uartdf_pkg::HLEN_W+1){1'b0}}, header_length_q}
		+ (uartdf_pkg::CNT_W+1)'(2);

	// Decode one byte against the frame state
	always_comb begin
		phase_d          = phase_q;
		byte_count_d     = byte_count_q;
		header_length_d  = header_length_q;
		running_xor_d    = running_xor_q;
		overflow_seen_d  = overflow_seen_q;
		store_valid_d    = 1'b0;
		store_index_d    = '0;
		store_byte_d     = '0;
		frame_done_d     = 1'b0;
		frame_good_d     = 1'b0;
		frame_length_d   = '0;
		frame_overflow_d = 1'b0;

		// Store the byte for every phase that writes the buffer
		if (phase_q == PH_TYPE || phase_q == PH_LEN_HI || phase_q == PH_LEN_LO
			|| phase_q == PH_BODY) begin
			byte_count_d = count_inc;
			if (in_buffer) begin
				store_valid_d = 1'b1;
				store_index_d = byte_count_q[uartdf_pkg::IDX_W-1:0];
				store_byte_d  = byte_s1;
			end else begin
				overflow_seen_d = 1'b1;
			end
		end

		unique case (phase_q)
			PH_TYPE: begin
				header_length_d = '0;
				phase_d         = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				running_xor_d   = running_xor_q ^ byte_s1;
				header_length_d = {byte_s1, 8'h00};
				phase_d         = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				running_xor_d   = running_xor_q ^ byte_s1;
				header_length_d = {header_length_q[15:8], byte_s1};
				phase_d         = PH_BODY;
			end
			PH_BODY: begin
				running_xor_d = running_xor_q ^ byte_s1;
				// close the body once the stored count reaches 2 + length
				if (body_end <= {1'b0, count_inc}) begin
					phase_d = (running_xor_d == '0) ? PH_TRAILER : PH_IDLE;
				end
			end
			PH_TRAILER: begin
				frame_done_d     = 1'b1;
				frame_good_d     = (byte_s1 == end_byte_q);
				frame_length_d   = {1'b0, header_length_q} + uartdf_pkg::FLEN_W'(1);
				frame_overflow_d = overflow_seen_q;
				phase_d          = PH_IDLE;
			end
			default: begin
				// hunt for the start byte
				if (byte_s1 == start_byte_q) begin
					byte_count_d    = '0;
					running_xor_d   = '0;
					header_length_d = '0;
					overflow_seen_d = 1'b0;
					phase_d         = PH_TYPE;
				end else begin
					phase_d = PH_IDLE;
				end
			end
		endcase
	end

	// Hold configuration, frame state and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q    <= uartdf_pkg::START_BYTE_RST;
			end_byte_q      <= uartdf_pkg::END_BYTE_RST;
			phase_q         <= PH_IDLE;
			byte_count_q    <= '0;
			header_length_q <= '0;
			running_xor_q   <= '0;
			overflow_seen_q <= 1'b0;
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					uartdf_pkg::REG_START_BYTE: start_byte_q <= cfg_wdata;
					uartdf_pkg::REG_END_BYTE:   end_byte_q   <= cfg_wdata;
					default: ;
				endcase
			end
			if (advance_s2) begin
				phase_q         <= phase_d;
				byte_count_q    <= byte_count_d;
				header_length_q <= header_length_d;
				running_xor_q   <= running_xor_d;
				overflow_seen_q <= overflow_seen_d;
			end
			if (take_s1) begin
				valid_s1 <= 1'b1;
			end else if (advance_s2) begin
				valid_s1 <= 1'b0;
			end
			if (advance_s2) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Capture the input byte
	always_ff @(posedge clk) begin
		if (take_s1) begin
			byte_s1 <= s_tdata;
		end
	end

	// Capture the result item
	always_ff @(posedge clk) begin
		if (advance_s2) begin
			store_valid_s2    <= store_valid_d;
			store_index_s2    <= store_index_d;
			store_byte_s2     <= store_byte_d;
			frame_done_s2     <= frame_done_d;
			frame_good_s2     <= frame_good_d;
			frame_length_s2   <= frame_length_d;
			frame_overflow_s2 <= frame_overflow_d;
		end
	end

	// Drive the result stream
	assign m_tvalid = valid_s2;
	assign m_tuser  = store_valid_s2;
	assign m_tlast  = frame_done_s2;
	assign m_tdata  = {1'b0, frame_overflow_s2, frame_length_s2, frame_good_s2,
		store_byte_s2, store_index_s2};

`ifndef SYNTHESIS
	// A trailer report never stores a byte
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(frame_done_s2 && store_valid_s2))
		else $error("trailer result also stores a byte");

	// Good and overflow flags appear only with frame done
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (frame_good_s2 || frame_overflow_s2) |-> frame_done_s2)
		else $error("frame flags without frame done");

	// Back-pressure upstream only when both stages are full and m_tready is low
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input stalled with free stages");

	// The trailer phase is entered only from the body phase
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TRAILER) && ($past(phase_q) != PH_TRAILER)
		|-> $past(phase_q) == PH_BODY)
		else $error("trailer phase entered from wrong phase");

	// A byte is stored only while the overflow flag is clear
	assert property (@(posedge clk) disable iff (!arst_n)
		advance_s2 && store_valid_d |-> !overflow_seen_d)
		else $error("byte stored after overflow");
`endif

endmodule
